// File: rtl/core/spirtc_pkg.sv
// Shared types and constants for the SPI register file with real-time clock.
// No dependencies.
package spirtc_pkg;

    localparam int unsigned REG_COUNT = 64;
    localparam int unsigned ADDR_W    = 6;
    localparam int unsigned DATA_W    = 24;
    localparam int unsigned CPS_W     = 30;
    localparam int unsigned SOD_W     = 17;
    localparam int unsigned DAYCNT_W  = 16;

    localparam logic [CPS_W-1:0] CPS_RESET = 30'd100000000;

    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [ADDR_W-1:0] ADDR_SECONDS = 6'd20;
    localparam logic [ADDR_W-1:0] ADDR_DAY     = 6'd22;

    localparam logic [SOD_W-1:0] SECS_PER_DAY = 17'd86400;
    localparam logic [SOD_W-1:0] SOD_LAST     = 17'd86399;

    // Seconds-of-day and day count reached at the last value before the
    // 32-bit seconds count wraps to zero.
    localparam logic [DAYCNT_W-1:0] DAY_WRAP = 16'(32'hFFFF_FFFF / 32'd86400);
    localparam logic [SOD_W-1:0]    SOD_WRAP = 17'(32'hFFFF_FFFF % 32'd86400);

    typedef struct packed {
        logic [SOD_W-1:0]    sod;
        logic [DAYCNT_W-1:0] day;
    } rtc_time_t;

endpackage

// File: rtl/core/spirtc_rtc.sv
// Real-time clock: tick prescaler, seconds of day and day count.
// Depends on spirtc_pkg.
module spirtc_rtc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick,
    input  logic [spirtc_pkg::CPS_W-1:0]  cps,
    output spirtc_pkg::rtc_time_t         rtc_time
);

    logic [spirtc_pkg::CPS_W-1:0] presc_reg;
    logic [spirtc_pkg::CPS_W-1:0] presc_next;
    logic [spirtc_pkg::CPS_W-1:0] presc_inc;
    logic [spirtc_pkg::CPS_W-1:0] limit;
    logic                         sec_inc;
    spirtc_pkg::rtc_time_t        time_reg;
    spirtc_pkg::rtc_time_t        time_next;

    always_comb
    begin
        limit     = (cps == '0) ? spirtc_pkg::CPS_W'(1) : cps;
        presc_inc = presc_reg + spirtc_pkg::CPS_W'(1);
        sec_inc   = tick && (presc_inc >= limit);
        presc_next = presc_reg;
        if (tick)
        begin
            presc_next = sec_inc ? '0 : presc_inc;
        end

        time_next = time_reg;
        if (sec_inc)
        begin
            if (time_reg.day == spirtc_pkg::DAY_WRAP && time_reg.sod == spirtc_pkg::SOD_WRAP)
            begin
                time_next = '0;
            end
            else if (time_reg.sod == spirtc_pkg::SOD_LAST)
            begin
                time_next.sod = '0;
                time_next.day = time_reg.day + spirtc_pkg::DAYCNT_W'(1);
            end
            else
            begin
                time_next.sod = time_reg.sod + spirtc_pkg::SOD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presc_reg <= '0;
            time_reg  <= '0;
        end
        else
        begin
            presc_reg <= presc_next;
            time_reg  <= time_next;
        end
    end

    assign rtc_time = time_reg;

endmodule

// File: rtl/core/spi_register_file_with_rtc_top.sv
// SPI register file with real-time clock: top level.
// Depends on spirtc_pkg and spirtc_rtc.
//
// One beat is taken per clock while in_stall is low: a tick beat
// (opcode 1) advances the RTC prescaler and gives no result; a command
// beat (opcode 0) gives one read_data beat via the registered read of the
// 64-entry register store and the output register. A write returns the
// previous contents; address 20 reads seconds of day and address 22 the
// day count masked to DAY_BITS. Input stalls only while both the command
// stage and the output register are full and the output is stalled.
// cycles_per_second sits at byte address 0 of the APB port.
module spi_register_file_with_rtc_top #(
    parameter int unsigned DAY_BITS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [31:0] command,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] read_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [spirtc_pkg::DATA_W-1:0] DAY_MASK =
        spirtc_pkg::DATA_W'((25'(1) << DAY_BITS) - 25'(1));

    logic [spirtc_pkg::CPS_W-1:0]  cps_reg;
    logic                          cfg_wr;

    logic                          accept;
    logic                          cmd_acc;
    logic                          tick;
    logic                          out_load;
    logic [spirtc_pkg::ADDR_W-1:0] in_addr;
    logic                          in_wr;
    logic [spirtc_pkg::DATA_W-1:0] in_data;

    logic [spirtc_pkg::DATA_W-1:0] store_reg [spirtc_pkg::REG_COUNT];
    logic [spirtc_pkg::REG_COUNT-1:0] ent_vld_reg;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s1_wr_reg;
    logic [spirtc_pkg::ADDR_W-1:0] s1_addr_reg;
    logic [spirtc_pkg::DATA_W-1:0] s1_rd_reg;
    logic                          s1_vld_reg;
    spirtc_pkg::rtc_time_t         s1_time_reg;
    spirtc_pkg::rtc_time_t         rtc_time;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [spirtc_pkg::DATA_W-1:0] result;
    logic [spirtc_pkg::DATA_W-1:0] read_data_reg;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? 32'(cps_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cps_reg <= spirtc_pkg::CPS_RESET;
        end
        else if (cfg_wr)
        begin
            cps_reg <= pwdata[spirtc_pkg::CPS_W-1:0];
        end
    end

    // Handshake
    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !out_load;
    assign accept   = in_valid && !in_stall;
    assign cmd_acc  = accept && (opcode == spirtc_pkg::OP_CMD);
    assign tick     = accept && (opcode == spirtc_pkg::OP_TICK);

    assign in_wr   = command[31];
    assign in_addr = command[30:25];
    assign in_data = command[23:0];

    spirtc_rtc u_rtc (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .cps      (cps_reg),
        .rtc_time (rtc_time)
    );

    // Register store: read first, then write, at the accepting edge
    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            s1_rd_reg <= store_reg[in_addr];
            if (in_wr)
            begin
                store_reg[in_addr] <= in_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= '0;
            s1_vld_reg  <= 1'b0;
        end
        else if (cmd_acc)
        begin
            s1_vld_reg <= ent_vld_reg[in_addr];
            if (in_wr)
            begin
                ent_vld_reg[in_addr] <= 1'b1;
            end
        end
    end

    // Command stage: hold fields and an RTC snapshot
    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            s1_wr_reg   <= in_wr;
            s1_addr_reg <= in_addr;
            s1_time_reg <= rtc_time;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        result = s1_vld_reg ? s1_rd_reg : '0;
        if (!s1_wr_reg)
        begin
            case (s1_addr_reg)
                spirtc_pkg::ADDR_SECONDS:
                begin
                    result = spirtc_pkg::DATA_W'(s1_time_reg.sod);
                end
                spirtc_pkg::ADDR_DAY:
                begin
                    result = spirtc_pkg::DATA_W'(s1_time_reg.day) & DAY_MASK;
                end
                default:
                begin
                    result = s1_vld_reg ? s1_rd_reg : '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            read_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    a_sod_range: assert property (@(posedge clk) disable iff (!rst_n)
        rtc_time.sod < spirtc_pkg::SECS_PER_DAY)
        else $error("seconds of day out of range");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        rtc_time.day <= spirtc_pkg::DAY_WRAP)
        else $error("day count beyond wrap point");

    a_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |=> s1_valid_reg)
        else $error("accepted command lost from command stage");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room downstream");

endmodule

// File: tb/tb_spi_register_file_with_rtc_top.sv
// Self-checking testbench for spi_register_file_with_rtc_top: random and directed SPI/tick beats,
// a built-in prediction of the register store and RTC, APB writes of cycles_per_second.
// Depends on spirtc_pkg and the RTL of spi_register_file_with_rtc_top.
module tb_spi_register_file_with_rtc_top;

    localparam int unsigned RTC_DAY_BITS = 15;
    localparam logic [2:0]  CPS_ADDR     = 3'd0;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned SETTLE       = 10;

    typedef struct packed {
        logic        opcode;
        logic [31:0] command;
    } spi_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = spirtc_pkg::OP_TICK;
    logic [31:0] command = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [23:0] read_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = CPS_ADDR;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    spi_beat_t   beat_q[$];
    logic [23:0] read_data_q[$];

    logic [23:0] reg_store[spirtc_pkg::REG_COUNT];
    logic [31:0] secs_count;
    logic [31:0] prescale;
    logic [29:0] cps_setting;

    int unsigned mismatches = 0;
    logic        calm = 1'b0;
    logic        in_acc = 1'b0;
    int unsigned hold_req = 0;
    int unsigned hold_ack = 0;
    int unsigned hold_left = 0;

    spi_register_file_with_rtc_top #(
        .DAY_BITS(RTC_DAY_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .command  (command),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] spi_word(logic wr, logic [5:0] addr, logic [23:0] data);
        return {wr, addr, 1'b0, data};
    endfunction

    task automatic advance_rtc();
        logic [31:0] limit;
        limit = (cps_setting == 30'd0) ? 32'd1 : {2'b00, cps_setting};
        prescale = prescale + 32'd1;
        if (prescale >= limit)
        begin
            prescale = 32'd0;
            secs_count = secs_count + 32'd1;
        end
    endtask

    function automatic logic [23:0] spi_response(logic [31:0] word);
        logic [5:0]  addr;
        logic [23:0] prev;
        logic [31:0] days;
        addr = word[30:25];
        if (word[31])
        begin
            prev = reg_store[addr];
            reg_store[addr] = word[23:0];
            return prev;
        end
        if (addr == spirtc_pkg::ADDR_SECONDS)
            return 24'(secs_count % 32'd86400);
        if (addr == spirtc_pkg::ADDR_DAY)
        begin
            days = secs_count / 32'd86400;
            return 24'(days & ((32'd1 << RTC_DAY_BITS) - 32'd1));
        end
        return reg_store[addr];
    endfunction

    always @(posedge clk)
    begin
        spi_beat_t b;
        in_acc = rst_n && in_valid && !in_stall;
        if (in_acc)
        begin
            b = beat_q.pop_front();
            if (b.opcode == spirtc_pkg::OP_TICK)
                advance_rtc();
            else
                read_data_q.push_back(spi_response(b.command));
        end
    end

    always @(negedge clk)
    begin
        if (in_valid && !in_acc)
        begin
            in_valid <= 1'b1;
        end
        else if (beat_q.size() == 0 || (!calm && $urandom_range(99) < 24))
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            in_valid <= 1'b1;
            opcode   <= beat_q[0].opcode;
            command  <= beat_q[0].command;
        end
    end

    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 24);
    end

    always @(posedge clk)
    begin
        logic [23:0] exp_data;
        if (rst_n && out_valid && !out_stall)
        begin
            if (read_data_q.size() == 0)
            begin
                $error("read_data: unexpected beat, actual %h", read_data);
                mismatches++;
            end
            else
            begin
                exp_data = read_data_q.pop_front();
                if (read_data !== exp_data)
                begin
                    $error("read_data: expected %h, actual %h", exp_data, read_data);
                    mismatches++;
                end
            end
        end
    end

    task automatic push_cmd(logic wr, logic [5:0] addr, logic [23:0] data);
        beat_q.push_back('{opcode: spirtc_pkg::OP_CMD, command: spi_word(wr, addr, data)});
    endtask

    task automatic push_ticks(int unsigned n);
        repeat (n) beat_q.push_back('{opcode: spirtc_pkg::OP_TICK, command: $urandom()});
    endtask

    task automatic wait_idle();
        while (beat_q.size() != 0 || read_data_q.size() != 0 || in_valid)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cps_write(logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CPS_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        cps_setting = value[29:0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {2'b00, cps_setting})
        begin
            $error("cycles_per_second: expected %h, actual %h", {2'b00, cps_setting}, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_burst(int unsigned n);
        logic [5:0] addr;
        repeat (n)
        begin
            if ($urandom_range(99) < 45)
                push_ticks(1);
            else
            begin
                addr = 6'($urandom());
                if ($urandom_range(3) == 0)
                    addr = $urandom_range(1) ? spirtc_pkg::ADDR_SECONDS
                                             : spirtc_pkg::ADDR_DAY;
                beat_q.push_back('{opcode: spirtc_pkg::OP_CMD,
                                   command: {1'($urandom()), addr, 25'($urandom())}});
            end
        end
    endtask

    initial
    begin
        logic [31:0] cps_list[5];
        foreach (reg_store[i]) reg_store[i] = 24'd0;
        secs_count  = 32'd0;
        prescale    = 32'd0;
        cps_setting = spirtc_pkg::CPS_RESET;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        push_cmd(1'b0, 6'd0, 24'h000000);
        push_cmd(1'b1, 6'd0, 24'hFFFFFF);
        push_cmd(1'b0, 6'd0, 24'h000000);
        push_cmd(1'b1, 6'd63, 24'hA5A5A5);
        beat_q.push_back('{opcode: spirtc_pkg::OP_CMD, command: 32'hFFFF_FFFF});
        push_cmd(1'b0, 6'd63, 24'h5A5A5A);
        push_cmd(1'b1, spirtc_pkg::ADDR_SECONDS, 24'h123456);
        push_cmd(1'b0, spirtc_pkg::ADDR_SECONDS, 24'h000000);
        push_cmd(1'b1, spirtc_pkg::ADDR_DAY, 24'h654321);
        push_cmd(1'b0, spirtc_pkg::ADDR_DAY, 24'h000000);
        push_cmd(1'b1, spirtc_pkg::ADDR_SECONDS, 24'h000001);
        push_cmd(1'b1, spirtc_pkg::ADDR_DAY, 24'h000000);
        push_ticks(4);
        push_cmd(1'b0, spirtc_pkg::ADDR_SECONDS, 24'h000000);
        beat_q.push_back('{opcode: spirtc_pkg::OP_CMD, command: 32'h0100_0000});
        wait_idle();

        cps_write(32'd0);
        push_ticks(3);
        push_cmd(1'b0, spirtc_pkg::ADDR_SECONDS, 24'h0);
        push_cmd(1'b0, spirtc_pkg::ADDR_DAY, 24'h0);
        wait_idle();

        cps_write(32'd50);
        push_ticks(40);
        push_cmd(1'b0, spirtc_pkg::ADDR_SECONDS, 24'h0);
        wait_idle();
        cps_write(32'd5);
        push_ticks(1);
        push_cmd(1'b0, spirtc_pkg::ADDR_SECONDS, 24'h0);
        wait_idle();

        cps_write(32'hFFFF_FFFF);
        push_ticks(5);
        push_cmd(1'b0, spirtc_pkg::ADDR_SECONDS, 24'h0);
        wait_idle();

        cps_list = '{32'd1, 32'd3, 32'd7, {2'b00, spirtc_pkg::CPS_RESET}, 32'd2};
        foreach (cps_list[i])
        begin
            cps_write(cps_list[i]);
            if (i == 1)
                hold_req++;
            calm = (i == 2);
            random_burst(85);
            wait_idle();
            calm = 1'b0;
        end

        cps_write(32'd1);
        push_cmd(1'b0, spirtc_pkg::ADDR_DAY, 24'h0);
        wait_idle();

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
